// File: hw/rtl/lav_pkg.sv
// ----------------------------------------------------------------------------
// lav_pkg
// Shared types and constants of the look-at view matrix pipeline.
// ----------------------------------------------------------------------------
package lav_pkg;

    // normalised mantissa: largest component lies in [2^NORM_LO, 2^(NORM_LO+1))
    localparam int NORM_LO = 29;
    localparam int MAN_W   = NORM_LO + 1;
    localparam int SQ_W    = 2 * MAN_W;
    localparam int SUM_W   = SQ_W + 2;
    localparam int ROOT_W  = SUM_W / 2;

    localparam logic [32:0] SAT_POS_MAG = 33'h0_7FFF_FFFF;
    localparam logic [32:0] SAT_NEG_MAG = 33'h0_8000_0000;
    localparam logic [31:0] SAT_MAX     = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN     = 32'h8000_0000;

    typedef enum logic [1:0] {
        ROW_LEFT = 2'd0,
        ROW_UP   = 2'd1,
        ROW_FWD  = 2'd2
    } t_row;

    typedef struct packed {
        logic [2:0][2:0][31:0] axis;
        logic [2:0][31:0]      trans;
        logic                  deg;
    } t_item;

endpackage

// File: hw/rtl/lookat_view_matrix.sv
// ----------------------------------------------------------------------------
// lookat_view_matrix
// Look-at view matrix builder in signed fixed point.
// ----------------------------------------------------------------------------
// Each transaction on the input carries eye, target and up vectors; the block
// returns three row transactions (left, up, forward axis with translation).
// The datapath is a fully pipelined chain of two normalisers (each with a
// 31-stage square root and a FRAC_BITS+1 stage divider) plus cross and dot
// product stages. The output stage emits three rows per matrix and takes
// the next matrix as the last row is accepted; the pipeline holds still
// while the output is stalled.
module lookat_view_matrix import lav_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_eye_x,
    input  logic signed [31:0] i_eye_y,
    input  logic signed [31:0] i_eye_z,
    input  logic signed [31:0] i_target_x,
    input  logic signed [31:0] i_target_y,
    input  logic signed [31:0] i_target_z,
    input  logic signed [31:0] i_up_x,
    input  logic signed [31:0] i_up_y,
    input  logic signed [31:0] i_up_z,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_row_index,
    output logic signed [31:0] o_col0,
    output logic signed [31:0] o_col1,
    output logic signed [31:0] o_col2,
    output logic signed [31:0] o_col3,
    output logic               o_degenerate,
    output logic               o_last_row
);

    localparam int FB    = FRAC_BITS;
    localparam int AW    = FB + 2;
    localparam int XPW   = FB + 34;
    localparam int CW    = FB + 35;
    localparam int FLPW  = 2 * FB + 4;
    localparam int FLW   = 2 * FB + 5;
    localparam int UW    = FB + 3;
    localparam int TPW   = FB + 35;
    localparam int DTW   = FB + 37;
    localparam int RMW   = DTW - FB + 1;
    localparam int FSW   = 192;
    localparam int LSW   = 96 + 3 * AW + 1;

    logic w_adv;
    logic w_take;

    // T1: input register
    logic               r1_v;
    logic signed [31:0] r1_eye [3];
    logic signed [31:0] r1_up  [3];
    logic signed [32:0] r1_d   [3];

    // forward normaliser
    logic                 fo_v;
    logic signed [AW-1:0] fo_f [3];
    logic                 fo_zero;
    logic [FSW-1:0]       fo_side;
    logic signed [31:0]   fo_eye [3];
    logic signed [31:0]   fo_up  [3];

    // T2: up x f products
    logic                  r2_v;
    logic signed [XPW-1:0] r2_pa [3];
    logic signed [XPW-1:0] r2_pb [3];
    logic signed [31:0]    r2_eye [3];
    logic signed [AW-1:0]  r2_f [3];
    logic                  r2_fz;
    logic signed [XPW-1:0] n2_pa [3];
    logic signed [XPW-1:0] n2_pb [3];

    // T3: cross differences
    logic                 r3_v;
    logic signed [CW-1:0] r3_c [3];
    logic signed [31:0]   r3_eye [3];
    logic signed [AW-1:0] r3_f [3];
    logic                 r3_fz;

    // left normaliser
    logic                 lo_v;
    logic signed [AW-1:0] lo_l [3];
    logic                 lo_zero;
    logic [LSW-1:0]       lo_side;
    logic signed [31:0]   lo_eye [3];
    logic signed [AW-1:0] lo_f [3];

    // T4: f x l products
    logic                   r4_v;
    logic signed [FLPW-1:0] r4_pa [3];
    logic signed [FLPW-1:0] r4_pb [3];
    logic signed [31:0]     r4_eye [3];
    logic signed [AW-1:0]   r4_f [3];
    logic signed [AW-1:0]   r4_l [3];
    logic                   r4_deg;
    logic signed [FLPW-1:0] n4_pa [3];
    logic signed [FLPW-1:0] n4_pb [3];

    // T5: f x l differences
    logic                  r5_v;
    logic signed [FLW-1:0] r5_fl [3];
    logic signed [31:0]    r5_eye [3];
    logic signed [AW-1:0]  r5_f [3];
    logic signed [AW-1:0]  r5_l [3];
    logic                  r5_deg;

    // T6: magnitudes of f x l
    logic                 r6_v;
    logic [FLW-1:0]       r6_mag [3];
    logic [2:0]           r6_neg;
    logic signed [31:0]   r6_eye [3];
    logic signed [AW-1:0] r6_f [3];
    logic signed [AW-1:0] r6_l [3];
    logic                 r6_deg;

    // T7: rounded up axis
    logic                 r7_v;
    logic signed [UW-1:0] r7_u [3];
    logic signed [31:0]   r7_eye [3];
    logic signed [AW-1:0] r7_f [3];
    logic signed [AW-1:0] r7_l [3];
    logic                 r7_deg;
    logic signed [UW-1:0] n7_u [3];

    // T8: axis times eye products, rows l u f
    logic                  r8_v;
    logic signed [TPW-1:0] r8_tp [3][3];
    logic signed [UW-1:0]  r8_ax [3][3];
    logic                  r8_deg;
    logic signed [UW-1:0]  n8_ax [3][3];

    // T9: dot products
    logic                  r9_v;
    logic signed [DTW-1:0] r9_dot [3];
    logic signed [UW-1:0]  r9_ax [3][3];
    logic                  r9_deg;

    // T10: dot magnitudes
    logic                 r10_v;
    logic [DTW-1:0]       r10_mag [3];
    logic [2:0]           r10_neg;
    logic signed [UW-1:0] r10_ax [3][3];
    logic                 r10_deg;

    // T11: rounded magnitudes
    logic                 r11_v;
    logic [RMW-1:0]       r11_rm [3];
    logic [2:0]           r11_neg;
    logic signed [UW-1:0] r11_ax [3][3];
    logic                 r11_deg;

    // T12: finished matrix
    logic  r12_v;
    t_item r12_item;
    t_item n12_item;

    assign w_adv      = !r12_v || w_take;
    assign o_in_ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v  <= 1'b0;
            r2_v  <= 1'b0;
            r3_v  <= 1'b0;
            r4_v  <= 1'b0;
            r5_v  <= 1'b0;
            r6_v  <= 1'b0;
            r7_v  <= 1'b0;
            r8_v  <= 1'b0;
            r9_v  <= 1'b0;
            r10_v <= 1'b0;
            r11_v <= 1'b0;
            r12_v <= 1'b0;
        end else if (w_adv) begin
            r1_v  <= i_in_valid;
            r2_v  <= fo_v;
            r3_v  <= r2_v;
            r4_v  <= lo_v;
            r5_v  <= r4_v;
            r6_v  <= r5_v;
            r7_v  <= r6_v;
            r8_v  <= r7_v;
            r9_v  <= r8_v;
            r10_v <= r9_v;
            r11_v <= r10_v;
            r12_v <= r11_v;
        end
    end

    // T1
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_eye[0] <= i_eye_x;
            r1_eye[1] <= i_eye_y;
            r1_eye[2] <= i_eye_z;
            r1_up[0]  <= i_up_x;
            r1_up[1]  <= i_up_y;
            r1_up[2]  <= i_up_z;
            r1_d[0]   <= 33'(i_eye_x) - 33'(i_target_x);
            r1_d[1]   <= 33'(i_eye_y) - 33'(i_target_y);
            r1_d[2]   <= 33'(i_eye_z) - 33'(i_target_z);
        end
    end

    lav_norm #(
        .IW   (33),
        .FRAC (FB),
        .SW   (FSW)
    ) u_norm_f (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r1_v),
        .i_vec   (r1_d),
        .i_side  ({r1_eye[0], r1_eye[1], r1_eye[2], r1_up[0], r1_up[1], r1_up[2]}),
        .o_valid (fo_v),
        .o_vec   (fo_f),
        .o_zero  (fo_zero),
        .o_side  (fo_side)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            fo_eye[i] = fo_side[FSW - 1 - 32 * i -: 32];
            fo_up[i]  = fo_side[95 - 32 * i -: 32];
        end
        n2_pa[0] = XPW'(fo_up[1]) * XPW'(fo_f[2]);
        n2_pb[0] = XPW'(fo_up[2]) * XPW'(fo_f[1]);
        n2_pa[1] = XPW'(fo_up[2]) * XPW'(fo_f[0]);
        n2_pb[1] = XPW'(fo_up[0]) * XPW'(fo_f[2]);
        n2_pa[2] = XPW'(fo_up[0]) * XPW'(fo_f[1]);
        n2_pb[2] = XPW'(fo_up[1]) * XPW'(fo_f[0]);
    end

    // T2, T3
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r2_pa[i]  <= n2_pa[i];
                r2_pb[i]  <= n2_pb[i];
                r2_eye[i] <= fo_eye[i];
                r2_f[i]   <= fo_f[i];
                r3_c[i]   <= CW'(r2_pa[i]) - CW'(r2_pb[i]);
                r3_eye[i] <= r2_eye[i];
                r3_f[i]   <= r2_f[i];
            end
            r2_fz <= fo_zero;
            r3_fz <= r2_fz;
        end
    end

    lav_norm #(
        .IW   (CW),
        .FRAC (FB),
        .SW   (LSW)
    ) u_norm_l (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r3_v),
        .i_vec   (r3_c),
        .i_side  ({r3_eye[0], r3_eye[1], r3_eye[2], r3_f[0], r3_f[1], r3_f[2], r3_fz}),
        .o_valid (lo_v),
        .o_vec   (lo_l),
        .o_zero  (lo_zero),
        .o_side  (lo_side)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            lo_eye[i] = lo_side[LSW - 1 - 32 * i -: 32];
            lo_f[i]   = lo_side[3 * AW - AW * i -: AW];
        end
        n4_pa[0] = FLPW'(lo_f[1]) * FLPW'(lo_l[2]);
        n4_pb[0] = FLPW'(lo_f[2]) * FLPW'(lo_l[1]);
        n4_pa[1] = FLPW'(lo_f[2]) * FLPW'(lo_l[0]);
        n4_pb[1] = FLPW'(lo_f[0]) * FLPW'(lo_l[2]);
        n4_pa[2] = FLPW'(lo_f[0]) * FLPW'(lo_l[1]);
        n4_pb[2] = FLPW'(lo_f[1]) * FLPW'(lo_l[0]);
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r6_neg[i]) begin
                n7_u[i] = -UW'((r6_mag[i] + (FLW'(1) << (FB - 1))) >> FB);
            end else begin
                n7_u[i] = UW'((r6_mag[i] + (FLW'(1) << (FB - 1))) >> FB);
            end
            n8_ax[0][i] = UW'(r7_l[i]);
            n8_ax[1][i] = r7_u[i];
            n8_ax[2][i] = UW'(r7_f[i]);
        end
    end

    // T4 .. T11
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r4_pa[i]  <= n4_pa[i];
                r4_pb[i]  <= n4_pb[i];
                r4_eye[i] <= lo_eye[i];
                r4_f[i]   <= lo_f[i];
                r4_l[i]   <= lo_l[i];
                r5_fl[i]  <= FLW'(r4_pa[i]) - FLW'(r4_pb[i]);
                r5_eye[i] <= r4_eye[i];
                r5_f[i]   <= r4_f[i];
                r5_l[i]   <= r4_l[i];
                r6_mag[i] <= r5_fl[i][FLW-1] ? FLW'(-r5_fl[i]) : FLW'(r5_fl[i]);
                r6_neg[i] <= r5_fl[i][FLW-1];
                r6_eye[i] <= r5_eye[i];
                r6_f[i]   <= r5_f[i];
                r6_l[i]   <= r5_l[i];
                r7_u[i]   <= n7_u[i];
                r7_eye[i] <= r6_eye[i];
                r7_f[i]   <= r6_f[i];
                r7_l[i]   <= r6_l[i];
            end
            for (int r = 0; r < 3; r++) begin
                for (int i = 0; i < 3; i++) begin
                    r8_tp[r][i]  <= TPW'(n8_ax[r][i]) * TPW'(r7_eye[i]);
                    r8_ax[r][i]  <= n8_ax[r][i];
                    r9_ax[r][i]  <= r8_ax[r][i];
                    r10_ax[r][i] <= r9_ax[r][i];
                    r11_ax[r][i] <= r10_ax[r][i];
                end
                r9_dot[r]  <= DTW'(r8_tp[r][0]) + DTW'(r8_tp[r][1]) + DTW'(r8_tp[r][2]);
                r10_mag[r] <= r9_dot[r][DTW-1] ? DTW'(-r9_dot[r]) : DTW'(r9_dot[r]);
                r10_neg[r] <= r9_dot[r][DTW-1];
                r11_rm[r]  <= RMW'((r10_mag[r] + (DTW'(1) << (FB - 1))) >> FB);
                r11_neg[r] <= r10_neg[r];
            end
            r4_deg  <= lo_zero | lo_side[0];
            r5_deg  <= r4_deg;
            r6_deg  <= r5_deg;
            r7_deg  <= r6_deg;
            r8_deg  <= r7_deg;
            r9_deg  <= r8_deg;
            r10_deg <= r9_deg;
            r11_deg <= r10_deg;
        end
    end

    // T12: saturate translation, widen axes, clear on degenerate input
    always_comb begin
        n12_item     = '0;
        n12_item.deg = r11_deg;
        if (!r11_deg) begin
            for (int r = 0; r < 3; r++) begin
                for (int i = 0; i < 3; i++) begin
                    n12_item.axis[r][i] = 32'(r11_ax[r][i]);
                end
                if (r11_neg[r]) begin
                    if (r11_rm[r] > RMW'(SAT_POS_MAG)) begin
                        n12_item.trans[r] = SAT_MAX;
                    end else begin
                        n12_item.trans[r] = r11_rm[r][31:0];
                    end
                end else begin
                    if (r11_rm[r] > RMW'(SAT_NEG_MAG)) begin
                        n12_item.trans[r] = SAT_MIN;
                    end else begin
                        n12_item.trans[r] = 32'(RMW'(0) - r11_rm[r]);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r12_item <= n12_item;
        end
    end

    lav_rows u_rows (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r12_v),
        .i_item       (r12_item),
        .i_ready      (i_out_ready),
        .o_take       (w_take),
        .o_valid      (o_out_valid),
        .o_row_index  (o_row_index),
        .o_col0       (o_col0),
        .o_col1       (o_col1),
        .o_col2       (o_col2),
        .o_col3       (o_col3),
        .o_degenerate (o_degenerate),
        .o_last_row   (o_last_row)
    );

endmodule

// File: hw/rtl/lav_isqrt.sv
// ----------------------------------------------------------------------------
// lav_isqrt
// Pipelined floor integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module lav_isqrt import lav_pkg::*; #(
    parameter int NW = 62,
    parameter int SW = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NW-1:0]     i_n,
    input  logic [SW-1:0]     i_side,
    output logic              o_valid,
    output logic [NW/2-1:0]   o_root,
    output logic [SW-1:0]     o_side
);

    localparam int RW   = NW / 2;
    localparam int REMW = RW + 3;

    logic            r_v    [RW];
    logic [REMW-1:0] r_rem  [RW];
    logic [RW-1:0]   r_root [RW];
    logic [NW-1:0]   r_n    [RW];
    logic [SW-1:0]   r_side [RW];

    for (genvar k = 0; k < RW; k++) begin : g_st
        logic            v_in;
        logic [REMW-1:0] rem_in;
        logic [RW-1:0]   root_in;
        logic [NW-1:0]   n_in;
        logic [SW-1:0]   side_in;
        logic [REMW-1:0] cur;
        logic [REMW-1:0] trial;
        logic [REMW-1:0] n_rem;
        logic [RW-1:0]   n_root;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign n_in    = i_n;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign n_in    = r_n[k-1];
            assign side_in = r_side[k-1];
        end

        always_comb begin
            cur   = {rem_in[REMW-3:0], n_in[NW-1 -: 2]};
            trial = REMW'({root_in, 2'b01});
            if (cur >= trial) begin
                n_rem  = cur - trial;
                n_root = {root_in[RW-2:0], 1'b1};
            end else begin
                n_rem  = cur;
                n_root = {root_in[RW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_n[k]    <= n_in << 2;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_v[RW-1];
    assign o_root  = r_root[RW-1];
    assign o_side  = r_side[RW-1];

endmodule

// File: hw/rtl/lav_div.sv
// ----------------------------------------------------------------------------
// lav_div
// Three-lane pipelined restoring divider sharing one divisor, one quotient
// bit per stage. Numerators must stay below den << QW.
// ----------------------------------------------------------------------------
module lav_div import lav_pkg::*; #(
    parameter int QW = 17,
    parameter int DW = 31,
    parameter int SW = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [DW+QW-1:0]    i_num [3],
    input  logic [DW-1:0]       i_den,
    input  logic [SW-1:0]       i_side,
    output logic                o_valid,
    output logic [QW-1:0]       o_q [3],
    output logic [SW-1:0]       o_side
);

    localparam int XW = DW + QW;

    logic          r_v    [QW];
    logic [XW-1:0] r_rem  [QW][3];
    logic [QW-1:0] r_q    [QW][3];
    logic [DW-1:0] r_den  [QW];
    logic [SW-1:0] r_side [QW];

    for (genvar k = 0; k < QW; k++) begin : g_st
        logic          v_in;
        logic [XW-1:0] rem_in [3];
        logic [QW-1:0] q_in   [3];
        logic [DW-1:0] den_in;
        logic [SW-1:0] side_in;
        logic [XW-1:0] sd;
        logic [XW-1:0] n_rem  [3];
        logic [QW-1:0] n_q    [3];

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign den_in  = i_den;
            assign side_in = i_side;
            for (genvar j = 0; j < 3; j++) begin : g_ln
                assign rem_in[j] = i_num[j];
                assign q_in[j]   = '0;
            end
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign den_in  = r_den[k-1];
            assign side_in = r_side[k-1];
            for (genvar j = 0; j < 3; j++) begin : g_ln
                assign rem_in[j] = r_rem[k-1][j];
                assign q_in[j]   = r_q[k-1][j];
            end
        end

        always_comb begin
            sd = XW'(den_in) << (QW - 1 - k);
            for (int j = 0; j < 3; j++) begin
                if (rem_in[j] >= sd) begin
                    n_rem[j] = rem_in[j] - sd;
                    n_q[j]   = {q_in[j][QW-2:0], 1'b1};
                end else begin
                    n_rem[j] = rem_in[j];
                    n_q[j]   = {q_in[j][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int j = 0; j < 3; j++) begin
                    r_rem[k][j] <= n_rem[j];
                    r_q[k][j]   <= n_q[j];
                end
                r_den[k]  <= den_in;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_side  = r_side[QW-1];
    for (genvar j = 0; j < 3; j++) begin : g_out
        assign o_q[j] = r_q[QW-1][j];
    end

endmodule

// File: hw/rtl/lav_norm.sv
// ----------------------------------------------------------------------------
// lav_norm
// Pipelined 3-vector normaliser: block shift to a fixed mantissa range,
// sum of squares, integer square root, rounded division per component.
// ----------------------------------------------------------------------------
module lav_norm import lav_pkg::*; #(
    parameter int IW   = 33,
    parameter int FRAC = 16,
    parameter int SW   = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic signed [IW-1:0]   i_vec [3],
    input  logic [SW-1:0]          i_side,
    output logic                   o_valid,
    output logic signed [FRAC+1:0] o_vec [3],
    output logic                   o_zero,
    output logic [SW-1:0]          o_side
);

    localparam int PW  = $clog2(IW);
    localparam int OW  = FRAC + 2;
    localparam int QW  = FRAC + 1;
    localparam int XW  = ROOT_W + QW;
    localparam int QSW = 3 * MAN_W + 4 + SW;
    localparam int DSW = 4 + SW;

    // stage 1: magnitudes
    logic          r1_v;
    logic [IW-1:0] r1_mag [3];
    logic [2:0]    r1_neg;
    logic [SW-1:0] r1_side;
    // stage 2: largest magnitude
    logic          r2_v;
    logic [IW-1:0] r2_mag [3];
    logic [IW-1:0] r2_mx;
    logic [2:0]    r2_neg;
    logic [SW-1:0] r2_side;
    // stage 3: leading one
    logic          r3_v;
    logic [IW-1:0] r3_mag [3];
    logic [PW-1:0] r3_pos;
    logic          r3_zero;
    logic [2:0]    r3_neg;
    logic [SW-1:0] r3_side;
    // stage 4: shifted mantissas
    logic             r4_v;
    logic [MAN_W-1:0] r4_m [3];
    logic             r4_zero;
    logic [2:0]       r4_neg;
    logic [SW-1:0]    r4_side;
    // stage 5: squares
    logic             r5_v;
    logic [SQ_W-1:0]  r5_sq [3];
    logic [MAN_W-1:0] r5_m [3];
    logic             r5_zero;
    logic [2:0]       r5_neg;
    logic [SW-1:0]    r5_side;
    // stage 6: sum of squares
    logic             r6_v;
    logic [SUM_W-1:0] r6_sum;
    logic [MAN_W-1:0] r6_m [3];
    logic             r6_zero;
    logic [2:0]       r6_neg;
    logic [SW-1:0]    r6_side;
    // stage 7: numerators
    logic              r7_v;
    logic [XW-1:0]     r7_num [3];
    logic [ROOT_W-1:0] r7_den;
    logic [DSW-1:0]    r7_side;
    // stage 8: signed result
    logic                 r8_v;
    logic signed [OW-1:0] r8_vec [3];
    logic                 r8_zero;
    logic [SW-1:0]        r8_side;

    logic [IW-1:0]      n1_mag [3];
    logic [IW-1:0]      n2_mx;
    logic [PW-1:0]      n3_pos;
    logic [MAN_W-1:0]   n4_m [3];
    logic [SQ_W-1:0]    n5_sq [3];
    logic [XW-1:0]      n7_num [3];
    logic signed [OW-1:0] n8_vec [3];

    logic              sq_v;
    logic [ROOT_W-1:0] sq_root;
    logic [QSW-1:0]    sq_side;
    logic [MAN_W-1:0]  sq_m [3];
    logic              dv_v;
    logic [QW-1:0]     dv_q [3];
    logic [DSW-1:0]    dv_side;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_mag[i] = i_vec[i][IW-1] ? IW'(-i_vec[i]) : IW'(i_vec[i]);
        end
        n2_mx = r1_mag[0];
        if (r1_mag[1] > n2_mx) begin
            n2_mx = r1_mag[1];
        end
        if (r1_mag[2] > n2_mx) begin
            n2_mx = r1_mag[2];
        end
        n3_pos = '0;
        for (int b = 0; b < IW; b++) begin
            if (r2_mx[b]) begin
                n3_pos = PW'(b);
            end
        end
        for (int i = 0; i < 3; i++) begin
            n4_m[i]  = MAN_W'({r3_mag[i], {NORM_LO{1'b0}}} >> r3_pos);
            n5_sq[i] = SQ_W'(r4_m[i]) * SQ_W'(r4_m[i]);
            sq_m[i]  = sq_side[SW + 4 + (2 - i) * MAN_W +: MAN_W];
            n7_num[i] = XW'({sq_m[i], {FRAC{1'b0}}}) + XW'(sq_root >> 1);
        end
        for (int i = 0; i < 3; i++) begin
            if (dv_side[SW]) begin
                n8_vec[i] = '0;
            end else if (dv_side[SW + 1 + i]) begin
                n8_vec[i] = -OW'(dv_q[i]);
            end else begin
                n8_vec[i] = OW'(dv_q[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
            r8_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= sq_v;
            r8_v <= dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_mag[i] <= n1_mag[i];
                r1_neg[i] <= i_vec[i][IW-1];
                r2_mag[i] <= r1_mag[i];
                r3_mag[i] <= r2_mag[i];
                r4_m[i]   <= n4_m[i];
                r5_sq[i]  <= n5_sq[i];
                r5_m[i]   <= r4_m[i];
                r6_m[i]   <= r5_m[i];
                r7_num[i] <= n7_num[i];
                r8_vec[i] <= n8_vec[i];
            end
            r1_side <= i_side;
            r2_mx   <= n2_mx;
            r2_neg  <= r1_neg;
            r2_side <= r1_side;
            r3_pos  <= n3_pos;
            r3_zero <= (r2_mx == '0);
            r3_neg  <= r2_neg;
            r3_side <= r2_side;
            r4_zero <= r3_zero;
            r4_neg  <= r3_neg;
            r4_side <= r3_side;
            r5_zero <= r4_zero;
            r5_neg  <= r4_neg;
            r5_side <= r4_side;
            r6_sum  <= SUM_W'(r5_sq[0]) + SUM_W'(r5_sq[1]) + SUM_W'(r5_sq[2]);
            r6_zero <= r5_zero;
            r6_neg  <= r5_neg;
            r6_side <= r5_side;
            r7_den  <= sq_root;
            r7_side <= sq_side[DSW-1:0];
            r8_zero <= dv_side[SW];
            r8_side <= dv_side[SW-1:0];
        end
    end

    lav_isqrt #(
        .NW (SUM_W),
        .SW (QSW)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r6_v),
        .i_n     (r6_sum),
        .i_side  ({r6_m[0], r6_m[1], r6_m[2], r6_neg, r6_zero, r6_side}),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    lav_div #(
        .QW (QW),
        .DW (ROOT_W),
        .SW (DSW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r7_v),
        .i_num   (r7_num),
        .i_den   (r7_den),
        .i_side  (r7_side),
        .o_valid (dv_v),
        .o_q     (dv_q),
        .o_side  (dv_side)
    );

    assign o_valid = r8_v;
    assign o_vec   = r8_vec;
    assign o_zero  = r8_zero;
    assign o_side  = r8_side;

endmodule

// File: hw/rtl/lav_rows.sv
// ----------------------------------------------------------------------------
// lav_rows
// Output stage: holds one finished matrix and hands out its three rows.
// ----------------------------------------------------------------------------
module lav_rows import lav_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_item              i_item,
    input  logic               i_ready,
    output logic               o_take,
    output logic               o_valid,
    output logic [1:0]         o_row_index,
    output logic signed [31:0] o_col0,
    output logic signed [31:0] o_col1,
    output logic signed [31:0] o_col2,
    output logic signed [31:0] o_col3,
    output logic               o_degenerate,
    output logic               o_last_row
);

    logic  r_full;
    t_row  r_row;
    t_item r_item;
    logic  n_full;
    t_row  n_row;
    t_row  w_row_inc;
    logic  w_last;
    logic  w_load;

    assign w_last = (r_row == ROW_FWD);
    assign o_take = !r_full || (i_ready && w_last);
    assign w_load = i_valid && o_take;

    always_comb begin
        unique case (r_row)
            ROW_LEFT: w_row_inc = ROW_UP;
            ROW_UP:   w_row_inc = ROW_FWD;
            default:  w_row_inc = ROW_LEFT;
        endcase
        priority if (w_load) begin
            n_full = 1'b1;
            n_row  = ROW_LEFT;
        end else if (r_full && i_ready) begin
            n_full = !w_last;
            n_row  = w_row_inc;
        end else begin
            n_full = r_full;
            n_row  = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_row  <= ROW_LEFT;
        end else begin
            r_full <= n_full;
            r_row  <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= i_item;
        end
    end

    always_comb begin
        o_valid      = r_full;
        o_row_index  = r_row;
        o_col0       = r_item.axis[r_row][0];
        o_col1       = r_item.axis[r_row][1];
        o_col2       = r_item.axis[r_row][2];
        o_col3       = r_item.trans[r_row];
        o_degenerate = r_item.deg;
        o_last_row   = w_last;
    end

endmodule
